// ===== design/assert_macros.svh =====
// Assertion helpers for the SRTF scheduler modules.
// Included by files that carry concurrent checks; needs a clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock outside reset.
`define AST_ALWAYS(lbl, p, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (p)) else $error(msg);

// Same-cycle implication outside reset.
`define AST_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`endif

// ===== design/srtf_pkg.sv =====
// Shared types and constants for the SRTF scheduler.
// No dependencies.
`default_nettype none
package srtf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int ID_W     = 8;
  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int TIME_W   = 24;
  localparam int STAT_W   = 3;
  localparam int DONE_W   = 5;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [STAT_W-1:0] ST_LOADED = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 3'd1;
  localparam logic [STAT_W-1:0] ST_IDLE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_RAN    = 3'd3;
  localparam logic [STAT_W-1:0] ST_DONE   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_PICK,
    S_UPD,
    S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap_in;   // latch input transaction, restart scan
    logic scan_en;  // walk the table
    logic pick_rd;  // read the chosen entry
    logic upd_do;   // run chosen job one unit, advance time
    logic fin_do;   // load tick result into output register
    logic load_do;  // append job and load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic cmp_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/srtf_ctrl.sv =====
// Sequencer for the SRTF scheduler: load, scan, pick, update, report.
// Depends on srtf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module srtf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           mode,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output srtf_pkg::cmd_t      cmd,
  input  wire srtf_pkg::sts_t sts
);
  import srtf_pkg::*;

  state_t state, state_next;
  logic   out_free;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = (mode == MODE_TICK) ? S_SCAN : S_LOAD;
      end
      S_LOAD: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_done && !sts.cmp_busy) state_next = S_PICK;
      end
      S_PICK: state_next = S_UPD;
      S_UPD:  state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.cap_in  = in_valid;
      S_LOAD: cmd.load_do = out_free;
      S_SCAN: cmd.scan_en = 1'b1;
      S_PICK: cmd.pick_rd = 1'b1;
      S_UPD:  cmd.upd_do  = 1'b1;
      S_FIN:  cmd.fin_do  = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.fin_do || cmd.load_do) out_valid_next = 1'b1;
  end

  `AST_IMPL(a_out_src, $rose(out_valid), $past(state) == S_FIN || $past(state) == S_LOAD, "result raised outside a report state")

endmodule
`default_nettype wire

// ===== design/srtf_datapath.sv =====
// Job table, minimum-remaining scan, run update and result register.
// Depends on srtf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module srtf_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire srtf_pkg::cmd_t                  cmd,
  output srtf_pkg::sts_t                       sts,
  input  wire logic [srtf_pkg::ID_W-1:0]       job_id,
  input  wire logic [srtf_pkg::ARR_W-1:0]      arrival,
  input  wire logic [srtf_pkg::BURST_W-1:0]    burst,
  output logic      [srtf_pkg::STAT_W-1:0]     status,
  output logic      [srtf_pkg::ID_W-1:0]       run_id,
  output logic      [srtf_pkg::TIME_W-1:0]     time_now,
  output logic      [srtf_pkg::TIME_W-1:0]     turnaround,
  output logic      [srtf_pkg::TIME_W-1:0]     waiting,
  output logic      [srtf_pkg::TIME_W-1:0]     response,
  output logic      [srtf_pkg::DONE_W-1:0]     done_count
);
  import srtf_pkg::*;

  // table memories, one read port, one write port
  logic [ID_W-1:0]    id_mem    [MAX_JOBS];
  logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [BURST_W-1:0] rem_mem   [MAX_JOBS];
  logic [TIME_W-1:0]  start_mem [MAX_JOBS];

  logic [MAX_JOBS-1:0] started;
  logic [MAX_JOBS-1:0] finished;
  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    finished_count;
  logic [TIME_W-1:0]   sim_time;

  // latched input transaction
  logic [ID_W-1:0]    id_in;
  logic [ARR_W-1:0]   arr_in;
  logic [BURST_W-1:0] burst_in;

  // registered read data
  logic [IDX_W-1:0]   rd_idx;
  logic [ID_W-1:0]    id_q;
  logic [ARR_W-1:0]   arr_q;
  logic [BURST_W-1:0] burst_q;
  logic [BURST_W-1:0] rem_q;
  logic [TIME_W-1:0]  start_q;

  // scan state
  logic [CNT_W-1:0]   scan_idx;
  logic               cmp_vld;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [BURST_W-1:0] best_rem;

  // run bookkeeping
  logic               fin_q;
  logic [TIME_W-1:0]  resp_start;
  logic [ARR_W:0]     arr_plus_burst;

  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               scan_issue;
  logic               scan_done;
  logic               elig;
  logic               load_ok;
  logic [IDX_W-1:0]   wr_idx;

  assign scan_done  = (scan_idx == entry_count);
  assign scan_issue = cmd.scan_en && !scan_done;
  assign rd_en      = scan_issue || cmd.pick_rd;
  assign rd_addr    = cmd.pick_rd ? best_idx : scan_idx[IDX_W-1:0];
  assign elig       = !finished[rd_idx] && (TIME_W'(arr_q) <= sim_time);
  assign load_ok    = (entry_count < CNT_W'(MAX_JOBS)) && (burst_in != '0);
  assign wr_idx     = entry_count[IDX_W-1:0];

  assign sts.scan_done = scan_done;
  assign sts.cmp_busy  = cmp_vld;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      id_in    <= job_id;
      arr_in   <= arrival;
      burst_in <= burst;
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx  <= rd_addr;
      id_q    <= id_mem[rd_addr];
      arr_q   <= arr_mem[rd_addr];
      burst_q <= burst_mem[rd_addr];
      rem_q   <= rem_mem[rd_addr];
      start_q <= start_mem[rd_addr];
    end
  end

  // memory write port: append on load, run update on tick
  always_ff @(posedge clk) begin
    if (cmd.load_do && load_ok) begin
      id_mem[wr_idx]    <= id_in;
      arr_mem[wr_idx]   <= arr_in;
      burst_mem[wr_idx] <= burst_in;
      rem_mem[wr_idx]   <= burst_in;
    end else if (cmd.upd_do && found) begin
      rem_mem[best_idx] <= rem_q - BURST_W'(1);
      if (!started[best_idx]) start_mem[best_idx] <= sim_time;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= '0;
      finished       <= '0;
      entry_count    <= '0;
      finished_count <= '0;
      sim_time       <= '0;
      scan_idx       <= '0;
      cmp_vld        <= 1'b0;
      found          <= 1'b0;
    end else begin
      cmp_vld <= scan_issue;
      if (cmd.cap_in) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (scan_issue) scan_idx <= scan_idx + CNT_W'(1);
        if (cmp_vld && elig && (!found || rem_q < best_rem)) found <= 1'b1;
      end
      if (cmd.load_do && load_ok) begin
        started[wr_idx]  <= 1'b0;
        finished[wr_idx] <= 1'b0;
        entry_count      <= entry_count + CNT_W'(1);
      end
      if (cmd.upd_do) begin
        sim_time <= sim_time + TIME_W'(1);
        if (found) begin
          started[best_idx] <= 1'b1;
          if (rem_q == BURST_W'(1)) begin
            finished[best_idx] <= 1'b1;
            finished_count     <= finished_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // best candidate so far; strict less-than keeps the lowest entry on ties
  always_ff @(posedge clk) begin
    if (!cmd.cap_in && cmp_vld && elig && (!found || rem_q < best_rem)) begin
      best_idx <= rd_idx;
      best_rem <= rem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_do) begin
      fin_q          <= found && (rem_q == BURST_W'(1));
      resp_start     <= started[best_idx] ? start_q : sim_time;
      arr_plus_burst <= {1'b0, arr_q} + {1'b0, burst_q};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_do) begin
      status     <= load_ok ? ST_LOADED : ST_REJECT;
      run_id     <= '0;
      time_now   <= sim_time;
      turnaround <= '0;
      waiting    <= '0;
      response   <= '0;
      done_count <= DONE_W'(finished_count);
    end else if (cmd.fin_do) begin
      status     <= !found ? ST_IDLE : (fin_q ? ST_DONE : ST_RAN);
      run_id     <= found ? id_q : '0;
      time_now   <= sim_time;
      done_count <= DONE_W'(finished_count);
      if (fin_q) begin
        turnaround <= sim_time - TIME_W'(arr_q);
        waiting    <= sim_time - TIME_W'(arr_plus_burst);
        response   <= resp_start - TIME_W'(arr_q);
      end else begin
        turnaround <= '0;
        waiting    <= '0;
        response   <= '0;
      end
    end
  end

  `AST_ALWAYS(a_count_max, entry_count <= CNT_W'(MAX_JOBS), "table count beyond capacity")
  `AST_ALWAYS(a_fin_le_cnt, finished_count <= entry_count, "more jobs finished than loaded")
  `AST_IMPL(a_best_in_range, found, CNT_W'(best_idx) < entry_count, "chosen entry not loaded")

endmodule
`default_nettype wire

// ===== design/srtf_scheduler_unit.sv =====
// Top level of the SRTF scheduler: controller plus datapath.
// Depends on srtf_pkg, srtf_ctrl and srtf_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | mode, job_id, arrival, burst
//   out     | out_valid/ out_stall | status, run_id, time_now, turnaround,
//           |                      | waiting, response, done_count
//
// A load result reaches the output register from the LOAD state; no new input is
// accepted until it is in the output register. A tick result follows a scan of
// every table entry, one entry per cycle through the single read port, a drain
// of the compare, then read, update and report of the pick.
// Inputs are accepted only while the sequencer is idle; a result waiting in
// the output register does not block the next accept, only the next report.
// rst is synchronous; it clears counters, time, started/finished flags and
// the handshake state. Table contents need no reset.
`default_nettype none
module srtf_scheduler_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         mode,
  input  wire logic [srtf_pkg::ID_W-1:0]    job_id,
  input  wire logic [srtf_pkg::ARR_W-1:0]   arrival,
  input  wire logic [srtf_pkg::BURST_W-1:0] burst,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [srtf_pkg::STAT_W-1:0]  status,
  output logic      [srtf_pkg::ID_W-1:0]    run_id,
  output logic      [srtf_pkg::TIME_W-1:0]  time_now,
  output logic      [srtf_pkg::TIME_W-1:0]  turnaround,
  output logic      [srtf_pkg::TIME_W-1:0]  waiting,
  output logic      [srtf_pkg::TIME_W-1:0]  response,
  output logic      [srtf_pkg::DONE_W-1:0]  done_count
);
  import srtf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns both handshakes
  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table, scan, arithmetic and result register
  srtf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .job_id     (job_id),
    .arrival    (arrival),
    .burst      (burst),
    .status     (status),
    .run_id     (run_id),
    .time_now   (time_now),
    .turnaround (turnaround),
    .waiting    (waiting),
    .response   (response),
    .done_count (done_count)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for srtf_scheduler_unit: SRTF job table loads and ticks.
// Needs srtf_pkg and the scheduler RTL; an internal predictor supplies the
// expected result of every accepted transaction.
module tb_top;
  import srtf_pkg::*;

  // one input transaction as the block sees it
  typedef struct packed {
    logic               mode;
    logic [ID_W-1:0]    job_id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
  } job_item_t;

  // queued stimulus; drain = hold off until every expected result is back
  typedef struct packed {
    bit        drain;
    job_item_t item;
  } stim_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   run_id;
    logic [TIME_W-1:0] time_now;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;
    logic [DONE_W-1:0] done_count;
  } sched_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = MODE_LOAD;
  logic [ID_W-1:0]    job_id = '0;
  logic [ARR_W-1:0]   arrival = '0;
  logic [BURST_W-1:0] burst = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    run_id;
  logic [TIME_W-1:0]  time_now;
  logic [TIME_W-1:0]  turnaround;
  logic [TIME_W-1:0]  waiting;
  logic [TIME_W-1:0]  response;
  logic [DONE_W-1:0]  done_count;

  srtf_scheduler_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .job_id     (job_id),
    .arrival    (arrival),
    .burst      (burst),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .run_id     (run_id),
    .time_now   (time_now),
    .turnaround (turnaround),
    .waiting    (waiting),
    .response   (response),
    .done_count (done_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stim_t         pending_items[$];
  sched_result_t expected_results[$];
  int            error_count = 0;
  int            results_seen = 0;

  // ---------------------------------------------------------------------------
  // Scheduler predictor: private copy of the job table, clock and counters.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]    tbl_id      [MAX_JOBS];
  logic [ARR_W-1:0]   tbl_arrival [MAX_JOBS];
  logic [BURST_W-1:0] tbl_burst   [MAX_JOBS];
  logic [BURST_W-1:0] tbl_left    [MAX_JOBS];
  logic [TIME_W-1:0]  tbl_start   [MAX_JOBS];
  bit                 tbl_started [MAX_JOBS];
  bit                 tbl_done    [MAX_JOBS];
  int                 tbl_count = 0;
  logic [TIME_W-1:0]  sched_clock = '0;
  int                 jobs_finished = 0;

  function automatic sched_result_t predict_schedule(job_item_t it);
    sched_result_t r;
    int            k;
    int            i;
    bit            found;
    r     = '0;
    k     = 0;
    found = 1'b0;
    if (it.mode == MODE_LOAD) begin
      if (tbl_count >= MAX_JOBS || it.burst == '0) begin
        r.status = ST_REJECT;
      end else begin
        tbl_id[tbl_count]      = it.job_id;
        tbl_arrival[tbl_count] = it.arrival;
        tbl_burst[tbl_count]   = it.burst;
        tbl_left[tbl_count]    = it.burst;
        tbl_start[tbl_count]   = '0;
        tbl_started[tbl_count] = 1'b0;
        tbl_done[tbl_count]    = 1'b0;
        tbl_count++;
        r.status = ST_LOADED;
      end
    end else begin
      // least remaining time among arrived, unfinished jobs; strict compare
      // keeps the lowest entry on a tie
      for (i = 0; i < tbl_count; i++) begin
        if (!tbl_done[i] && {8'h00, tbl_arrival[i]} <= sched_clock) begin
          if (!found || tbl_left[i] < tbl_left[k]) begin
            k     = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        sched_clock = sched_clock + 1'b1;
        r.status    = ST_IDLE;
      end else begin
        if (!tbl_started[k]) begin
          tbl_start[k]   = sched_clock;
          tbl_started[k] = 1'b1;
        end
        tbl_left[k] = tbl_left[k] - 1'b1;
        sched_clock = sched_clock + 1'b1;
        r.run_id    = tbl_id[k];
        if (tbl_left[k] == '0) begin
          tbl_done[k] = 1'b1;
          jobs_finished++;
          r.status     = ST_DONE;
          // all time differences wrap at the 24-bit clock width
          r.turnaround = sched_clock - {8'h00, tbl_arrival[k]};
          r.waiting    = r.turnaround - {8'h00, tbl_burst[k]};
          r.response   = tbl_start[k] - {8'h00, tbl_arrival[k]};
        end else begin
          r.status = ST_RAN;
        end
      end
    end
    r.time_now   = sched_clock;
    r.done_count = jobs_finished[DONE_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders. The generator mirrors the table fill and the clock
  // (every tick advances time by one) so arrivals can be aimed near "now".
  // ---------------------------------------------------------------------------
  int gen_count = 0;
  int gen_ticks = 0;

  task automatic push_load(input logic [ID_W-1:0] id, input int arr,
                           input logic [BURST_W-1:0] b, input bit drain);
    stim_t s;
    s.drain        = drain;
    s.item.mode    = MODE_LOAD;
    s.item.job_id  = id;
    s.item.arrival = arr[ARR_W-1:0];
    s.item.burst   = b;
    pending_items.insert(pending_items.size(), s);
    if (gen_count < MAX_JOBS && b != '0)
      gen_count++;
  endtask

  task automatic push_tick(input bit drain);
    stim_t s;
    s.drain       = drain;
    s.item.mode   = MODE_TICK;
    // tick payload is don't-care; random content toggles the pins anyway
    s.item.job_id  = ID_W'($urandom_range(0, 255));
    s.item.arrival = ARR_W'($urandom_range(0, 65535));
    s.item.burst   = BURST_W'($urandom_range(0, 65535));
    pending_items.insert(pending_items.size(), s);
    gen_ticks++;
  endtask

  // well-formed load: small burst, arrival a little before or after now
  task automatic push_job(input bit drain);
    int arr;
    if ($urandom_range(0, 1) == 1)
      arr = gen_ticks + $urandom_range(0, 20);
    else
      arr = gen_ticks - $urandom_range(0, 10);
    if (arr < 0)
      arr = 0;
    push_load(ID_W'($urandom_range(0, 255)), arr, BURST_W'($urandom_range(1, 30)), drain);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; payload held while
  // stalled; a drain-marked item waits until the result queue is empty.
  // ---------------------------------------------------------------------------
  job_item_t cur_item;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin : drive_proc
    bit    taken;
    stim_t s;
    taken = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (taken)
        expected_results.insert(expected_results.size(), predict_schedule(cur_item));
      if (in_valid && !taken) begin
        // stalled: keep the transaction on the pins
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain && expected_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        s        = pending_items.pop_front();
        cur_item = s.item;
        in_valid <= 1'b1;
        mode     <= s.item.mode;
        job_id   <= s.item.job_id;
        arrival  <= s.item.arrival;
        burst    <= s.item.burst;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: stall density re-picked among four levels, plus one long
  // hold-off so the output register backs up and the block stalls its input.
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int hold_left = 0;
  int stall_pct = 0;

  always @(posedge clk) begin : stall_proc
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1500)
        hold_left = 400;
      if (rx_cycle % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each output transaction checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("tb_top mismatch @%0t result %0d: %s", $realtime, results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(input string fld, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", fld, got, want));
  endtask

  always @(posedge clk) begin : check_proc
    sched_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("status", status, want.status);
        check_field("run_id", run_id, want.run_id);
        check_field("time_now", time_now, want.time_now);
        check_field("turnaround", turnaround, want.turnaround);
        check_field("waiting", waiting, want.waiting);
        check_field("response", response, want.response);
        check_field("done_count", done_count, want.done_count);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_proc
    int n;
    int roll;
    // directed: idle tick on an empty table, zero-burst reject, a tie on
    // remaining time, a late short job that preempts, a job that never
    // arrives with all-ones fields
    push_tick(1'b0);
    push_load(8'hFF, 16'hFFFF, 16'h0000, 1'b0);
    push_load(8'h00, 0, 16'd3, 1'b0);
    push_load(8'hFF, 0, 16'd3, 1'b0);
    push_load(8'h5A, 2, 16'd1, 1'b0);
    push_load(8'hA5, 16'hFFFF, 16'hFFFF, 1'b0);
    repeat (10) push_tick(1'b0);
    // load after ticks with arrival already past: eligible at once
    push_load(8'h3C, 0, 16'd2, 1'b1);
    repeat (3) push_tick(1'b0);

    // random: mostly ticks, sparse well-formed loads, rejected-load noise
    for (n = 0; n < 480; n++) begin
      if (n == 380) begin
        // fill the table; last slot is an always-eligible huge job
        while (gen_count < MAX_JOBS - 1)
          push_job(1'b1);
        push_load(ID_W'($urandom_range(0, 255)), 0, 16'hFFFF, 1'b0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3 && gen_count < MAX_JOBS - 2)
        push_job(n % 120 == 0);
      else if (roll < 13)
        // before the table fills, noise carries a zero burst so it is rejected
        push_load(ID_W'($urandom_range(0, 255)), $urandom_range(0, 65535),
                  (gen_count >= MAX_JOBS) ? BURST_W'($urandom_range(0, 65535)) : '0,
                  n % 120 == 0);
      else
        push_tick(n % 120 == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("expected results left over");

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : limit_proc
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
